>>> src/peg_pkg.sv
// Shared types, codes and constants of the primitive edge generator.
package peg_pkg;

   // Field widths.
   localparam int VERTEX_W    = 16;
   localparam int MODE_W      = 4;
   localparam int COUNT_W     = 11;
   localparam int CMD_W       = 2;
   localparam int CORNERS_W   = 3;
   localparam int PHASE_W     = 4;
   localparam int SEEN_W      = 2;
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = COUNT_W;
   localparam int RSP_DATA_W  = 72;
   localparam int RSP_USED_W  = 1 + 4 * VERTEX_W + CORNERS_W;

   // Job queue between the front and the back.
   localparam int JOBS_MAX    = 3;
   localparam int CODE_W      = 3;
   localparam int NUM_W       = 2;
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = 2;
   localparam int QCNT_W      = 3;

   // Command codes carried in req_tuser.
   localparam logic [CMD_W-1:0] CMD_INDEX  = 2'd0;
   localparam logic [CMD_W-1:0] CMD_MARK   = 2'd1;
   localparam logic [CMD_W-1:0] CMD_UNMARK = 2'd2;

   // Drawing modes.
   localparam logic [MODE_W-1:0] MODE_POINTS     = 4'd0;
   localparam logic [MODE_W-1:0] MODE_LINES      = 4'd1;
   localparam logic [MODE_W-1:0] MODE_LOOP       = 4'd2;
   localparam logic [MODE_W-1:0] MODE_STRIP      = 4'd3;
   localparam logic [MODE_W-1:0] MODE_TRIS       = 4'd4;
   localparam logic [MODE_W-1:0] MODE_TRI_STRIP  = 4'd5;
   localparam logic [MODE_W-1:0] MODE_FAN        = 4'd6;
   localparam logic [MODE_W-1:0] MODE_QUADS      = 4'd7;
   localparam logic [MODE_W-1:0] MODE_QUAD_STRIP = 4'd8;
   localparam logic [MODE_W-1:0] MODE_POLYGON    = 4'd9;

   // Configuration register indexes.
   localparam logic [CSR_INDEX_W-1:0] CSR_DRAW_MODE    = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_VERTEX_COUNT = 2'd1;

   // Result codes of one job entry.
   localparam logic [CODE_W-1:0] JOB_NONE       = 3'd0;
   localparam logic [CODE_W-1:0] JOB_FACE_PREV  = 3'd1;
   localparam logic [CODE_W-1:0] JOB_FACE_FAN   = 3'd2;
   localparam logic [CODE_W-1:0] JOB_FACE_QUAD  = 3'd3;
   localparam logic [CODE_W-1:0] JOB_WIRE_P1    = 3'd4;
   localparam logic [CODE_W-1:0] JOB_WIRE_P2    = 3'd5;
   localparam logic [CODE_W-1:0] JOB_WIRE_P3    = 3'd6;
   localparam logic [CODE_W-1:0] JOB_WIRE_FIRST = 3'd7;

   // Result item kinds.
   localparam logic KIND_WIRE = 1'b0;
   localparam logic KIND_FACE = 1'b1;

   // Corner counts.
   localparam logic [CORNERS_W-1:0] CORNERS_WIRE = 3'd2;
   localparam logic [CORNERS_W-1:0] CORNERS_TRI  = 3'd3;
   localparam logic [CORNERS_W-1:0] CORNERS_QUAD = 3'd4;

   // One classified index element: its corners, their highlight bits and
   // the ordered list of results that it causes.
   typedef struct packed {
      logic [VERTEX_W-1:0]                 v;
      logic [VERTEX_W-1:0]                 p1;
      logic [VERTEX_W-1:0]                 p2;
      logic [VERTEX_W-1:0]                 p3;
      logic [VERTEX_W-1:0]                 first;
      logic                                lit_v;
      logic                                lit1;
      logic                                lit2;
      logic                                lit3;
      logic                                litf;
      logic [JOBS_MAX-1:0][CODE_W-1:0]     code;
      logic [NUM_W-1:0]                    num;
   } peg_job_type;

   // Position modulo three for positions below twelve.
   function automatic logic [1:0] mod3(input logic [PHASE_W-1:0] p);
      logic [1:0] r;
      case (p)
         4'd0, 4'd3, 4'd6, 4'd9:  r = 2'd0;
         4'd1, 4'd4, 4'd7, 4'd10: r = 2'd1;
         4'd2, 4'd5, 4'd8, 4'd11: r = 2'd2;
         default:                 r = 2'd0;
      endcase
      return r;
   endfunction

endpackage

>>> src/peg_ram.sv
// Generic single-write, single-read RAM with registered read data.
module peg_ram #(
   parameter int WIDTH = 1,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port and registered read port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

>>> src/peg_front.sv
// Front part: keeps the index history and classifies each item into a job.
module peg_front import peg_pkg::*; #(
   parameter int MAX_VERTICES = 1024
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                acc_valid,
   input  logic [CMD_W-1:0]    acc_cmd,
   input  logic [VERTEX_W-1:0] acc_vertex,
   input  logic                acc_last,
   input  logic                lit_rdata,
   input  logic [MODE_W-1:0]   draw_mode,
   input  logic [COUNT_W-1:0]  vertex_count,
   output logic                job_valid,
   output peg_job_type         job,
   output logic                busy
);

   localparam logic [VERTEX_W:0] MAX_LIMIT = (VERTEX_W+1)'(MAX_VERTICES);

   // Item stage, aligned with the highlight read data.
   logic                s1_valid_ff;
   logic [CMD_W-1:0]    s1_cmd_ff;
   logic [VERTEX_W-1:0] s1_v_ff;
   logic                s1_last_ff;

   // History state.
   logic [PHASE_W-1:0]  phase_ff, phase_in;
   logic [SEEN_W-1:0]   seen_ff, seen_in;
   logic [VERTEX_W-1:0] p1_ff, p1_in, p2_ff, p2_in, p3_ff, p3_in, first_ff, first_in;
   logic                lit1_ff, lit1_in, lit2_ff, lit2_in, lit3_ff, lit3_in;
   logic                litf_ff, litf_in;

   logic                is_index;
   logic                is_mark;
   logic                v_below;
   logic                lit_v;
   logic [VERTEX_W-1:0] first_v;
   logic                first_lit;
   logic                rng_v, rng_p1, rng_p2, rng_p3, rng_f;
   logic [1:0]          p_mod3;
   logic [1:0]          p_mod4;
   logic                face_on;
   logic [CODE_W-1:0]   face_code;
   logic                face_ok;
   logic                w1, w2, w3, wf;
   logic [4:0]          cand_ok;
   logic [4:0][CODE_W-1:0] cand_code;
   peg_job_type         job_c;

   function automatic logic below_max(input logic [VERTEX_W-1:0] x);
      return {1'b0, x} < MAX_LIMIT;
   endfunction

   function automatic logic in_rng(input logic [VERTEX_W-1:0] x,
                                   input logic [COUNT_W-1:0]  cnt);
      return below_max(x) && (x < {{(VERTEX_W-COUNT_W){1'b0}}, cnt});
   endfunction

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= acc_valid;
      end
      s1_cmd_ff  <= acc_cmd;
      s1_v_ff    <= acc_vertex;
      s1_last_ff <= acc_last;
   end

   // Item decode and range checks.
   assign is_index  = s1_valid_ff && (s1_cmd_ff == CMD_INDEX);
   assign is_mark   = s1_valid_ff && ((s1_cmd_ff == CMD_MARK) || (s1_cmd_ff == CMD_UNMARK));
   assign v_below   = below_max(s1_v_ff);
   assign lit_v     = lit_rdata && v_below;
   assign first_v   = (seen_ff == '0) ? s1_v_ff : first_ff;
   assign first_lit = (seen_ff == '0) ? lit_v : litf_ff;
   assign rng_v     = in_rng(s1_v_ff, vertex_count);
   assign rng_p1    = in_rng(p1_ff, vertex_count);
   assign rng_p2    = in_rng(p2_ff, vertex_count);
   assign rng_p3    = in_rng(p3_ff, vertex_count);
   assign rng_f     = in_rng(first_v, vertex_count);
   assign p_mod3    = mod3(phase_ff);
   assign p_mod4    = phase_ff[1:0];

   // Face selection by mode; a face shows only when every corner is lit.
   always_comb begin
      face_on   = 1'b0;
      face_code = JOB_NONE;
      face_ok   = 1'b0;
      case (draw_mode)
         MODE_TRIS: begin
            face_on   = (p_mod3 == 2'd2);
            face_code = JOB_FACE_PREV;
         end
         MODE_TRI_STRIP: begin
            face_on   = (seen_ff >= 2'd2);
            face_code = JOB_FACE_PREV;
         end
         MODE_FAN: begin
            face_on   = (seen_ff >= 2'd2);
            face_code = JOB_FACE_FAN;
         end
         MODE_QUADS, MODE_QUAD_STRIP: begin
            face_on   = (p_mod4 == 2'd3);
            face_code = JOB_FACE_QUAD;
         end
         default: begin
            face_on   = 1'b0;
            face_code = JOB_NONE;
         end
      endcase
      case (face_code)
         JOB_FACE_PREV: face_ok = rng_p1 && rng_p2 && lit_v && lit1_ff && lit2_ff;
         JOB_FACE_FAN:  face_ok = rng_p1 && rng_f && lit_v && lit1_ff && first_lit;
         JOB_FACE_QUAD: face_ok = rng_p1 && rng_p2 && rng_p3 && lit_v && lit1_ff &&
                                  lit2_ff && lit3_ff;
         default:       face_ok = 1'b0;
      endcase
   end

   // Wire selection by mode and position.
   always_comb begin
      w1 = (seen_ff >= 2'd1) &&
           (((draw_mode == MODE_LINES) && phase_ff[0]) || (draw_mode == MODE_LOOP) ||
            (draw_mode == MODE_STRIP) || ((draw_mode == MODE_TRIS) && (p_mod3 != 2'd0)) ||
            (draw_mode == MODE_TRI_STRIP) || (draw_mode == MODE_FAN) ||
            ((draw_mode == MODE_QUADS) && (p_mod4 != 2'd0)) ||
            ((draw_mode == MODE_QUAD_STRIP) && phase_ff[0]) || (draw_mode == MODE_POLYGON));
      w2 = (seen_ff >= 2'd2) &&
           ((draw_mode == MODE_TRI_STRIP) || ((draw_mode == MODE_TRIS) && (p_mod3 == 2'd2)) ||
            (draw_mode == MODE_QUAD_STRIP));
      w3 = (draw_mode == MODE_QUADS) && (p_mod4 == 2'd3) && (seen_ff == 2'd3);
      wf = (((draw_mode == MODE_LOOP) || (draw_mode == MODE_POLYGON)) && s1_last_ff) ||
           (draw_mode == MODE_FAN);
   end

   // Candidate results in output order, then packed into the job list.
   always_comb begin
      logic [NUM_W-1:0] n;
      n = '0;
      cand_ok[0]   = face_on && face_ok;
      cand_ok[1]   = w1 && rng_p1;
      cand_ok[2]   = w2 && rng_p2;
      cand_ok[3]   = w3 && rng_p3;
      cand_ok[4]   = wf && rng_f;
      cand_code[0] = face_code;
      cand_code[1] = JOB_WIRE_P1;
      cand_code[2] = JOB_WIRE_P2;
      cand_code[3] = JOB_WIRE_P3;
      cand_code[4] = JOB_WIRE_FIRST;
      job_c.code   = '0;
      for (int i = 0; i < 5; i++) begin
         if (cand_ok[i] && (n != NUM_W'(JOBS_MAX))) begin
            job_c.code[n] = cand_code[i];
            n = n + 1'b1;
         end
      end
      job_c.num   = n;
      job_c.v     = s1_v_ff;
      job_c.p1    = p1_ff;
      job_c.p2    = p2_ff;
      job_c.p3    = p3_ff;
      job_c.first = first_v;
      job_c.lit_v = lit_v;
      job_c.lit1  = lit1_ff;
      job_c.lit2  = lit2_ff;
      job_c.lit3  = lit3_ff;
      job_c.litf  = first_lit;
   end

   assign job_valid = is_index && rng_v && (job_c.num != '0);
   assign job       = job_c;
   assign busy      = s1_valid_ff;

   // History update: index elements shift it, mark commands refresh lit bits.
   always_comb begin
      phase_in = phase_ff;
      seen_in  = seen_ff;
      p1_in    = p1_ff;
      p2_in    = p2_ff;
      p3_in    = p3_ff;
      first_in = first_ff;
      lit1_in  = lit1_ff;
      lit2_in  = lit2_ff;
      lit3_in  = lit3_ff;
      litf_in  = litf_ff;
      if (is_index) begin
         p1_in    = s1_v_ff;
         p2_in    = p1_ff;
         p3_in    = p2_ff;
         lit1_in  = lit_v;
         lit2_in  = lit1_ff;
         lit3_in  = lit2_ff;
         first_in = first_v;
         litf_in  = first_lit;
         if (s1_last_ff) begin
            phase_in = '0;
            seen_in  = '0;
         end else begin
            phase_in = (phase_ff == 4'd11) ? '0 : phase_ff + 1'b1;
            seen_in  = (seen_ff == 2'd3) ? seen_ff : seen_ff + 1'b1;
         end
      end else if (is_mark && v_below) begin
         if (p1_ff == s1_v_ff) begin
            lit1_in = (s1_cmd_ff == CMD_MARK);
         end
         if (p2_ff == s1_v_ff) begin
            lit2_in = (s1_cmd_ff == CMD_MARK);
         end
         if (p3_ff == s1_v_ff) begin
            lit3_in = (s1_cmd_ff == CMD_MARK);
         end
         if (first_ff == s1_v_ff) begin
            litf_in = (s1_cmd_ff == CMD_MARK);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= '0;
         seen_ff  <= '0;
         p1_ff    <= '0;
         p2_ff    <= '0;
         p3_ff    <= '0;
         first_ff <= '0;
         lit1_ff  <= 1'b0;
         lit2_ff  <= 1'b0;
         lit3_ff  <= 1'b0;
         litf_ff  <= 1'b0;
      end else begin
         phase_ff <= phase_in;
         seen_ff  <= seen_in;
         p1_ff    <= p1_in;
         p2_ff    <= p2_in;
         p3_ff    <= p3_in;
         first_ff <= first_in;
         lit1_ff  <= lit1_in;
         lit2_ff  <= lit2_in;
         lit3_ff  <= lit3_in;
         litf_ff  <= litf_in;
      end
   end

endmodule

>>> src/peg_queue.sv
// Short job queue between the front and the back.
module peg_queue import peg_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  peg_job_type       push_job,
   input  logic              pop,
   output logic              head_valid,
   output peg_job_type       head_job,
   output logic [QCNT_W-1:0] count
);

   peg_job_type       slot_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [QCNT_W-1:0] count_ff;

   // Job storage, written at the tail.
   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_job;
      end
   end

   // Pointers and fill level.
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + 1'b1;
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + 1'b1;
         end
         if (push && !pop) begin
            count_ff <= count_ff + 1'b1;
         end else if (pop && !push) begin
            count_ff <= count_ff - 1'b1;
         end
      end
   end

   assign head_valid = (count_ff != '0);
   assign head_job   = slot_ff[rd_ptr_ff];
   assign count      = count_ff;

endmodule

>>> src/peg_back.sv
// Back part: expands the head job into result items, one per cycle while rsp_tready is high.
module peg_back import peg_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  head_valid,
   input  peg_job_type           head_job,
   output logic                  pop,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata,
   output logic                  rsp_tuser,
   output logic                  rsp_tlast
);

   logic [NUM_W-1:0]     idx_ff, idx_in;
   logic [CODE_W-1:0]    code;
   logic                 last_one;
   logic                 kind;
   logic                 lit;
   logic [VERTEX_W-1:0]  cb, cc, cd;
   logic [CORNERS_W-1:0] corners;

   assign code     = head_job.code[idx_ff];
   assign last_one = (idx_ff == head_job.num - 1'b1);

   // Decode the current result code into the result fields.
   always_comb begin
      kind    = KIND_WIRE;
      lit     = 1'b0;
      cb      = '0;
      cc      = '0;
      cd      = '0;
      corners = CORNERS_WIRE;
      case (code)
         JOB_FACE_PREV: begin
            kind    = KIND_FACE;
            lit     = 1'b1;
            cb      = head_job.p1;
            cc      = head_job.p2;
            corners = CORNERS_TRI;
         end
         JOB_FACE_FAN: begin
            kind    = KIND_FACE;
            lit     = 1'b1;
            cb      = head_job.p1;
            cc      = head_job.first;
            corners = CORNERS_TRI;
         end
         JOB_FACE_QUAD: begin
            kind    = KIND_FACE;
            lit     = 1'b1;
            cb      = head_job.p1;
            cc      = head_job.p2;
            cd      = head_job.p3;
            corners = CORNERS_QUAD;
         end
         JOB_WIRE_P1: begin
            lit = head_job.lit_v && head_job.lit1;
            cb  = head_job.p1;
         end
         JOB_WIRE_P2: begin
            lit = head_job.lit_v && head_job.lit2;
            cb  = head_job.p2;
         end
         JOB_WIRE_P3: begin
            lit = head_job.lit_v && head_job.lit3;
            cb  = head_job.p3;
         end
         JOB_WIRE_FIRST: begin
            lit = head_job.lit_v && head_job.litf;
            cb  = head_job.first;
         end
         default: begin
            kind = KIND_WIRE;
         end
      endcase
   end

   assign rsp_tvalid = head_valid;
   assign rsp_tuser  = kind;
   assign rsp_tlast  = last_one;
   assign rsp_tdata  = {{(RSP_DATA_W-RSP_USED_W){1'b0}}, corners, cd, cc, cb,
                        head_job.v, lit};
   assign pop        = head_valid && rsp_tready && last_one;

   // Result position within the head job.
   always_comb begin
      idx_in = idx_ff;
      if (head_valid && rsp_tready) begin
         idx_in = last_one ? '0 : idx_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff <= '0;
      end else begin
         idx_ff <= idx_in;
      end
   end

endmodule

>>> src/primitive_edge_generator_core.sv
// Top level of the primitive edge generator: channels, configuration and bitmap.
//
// The req channel carries commands: req_tuser holds the command (list index,
// mark, unmark), req_tdata the vertex and req_tlast closes an index list.
// For each index the rsp channel returns up to three items, a highlighted
// face first and then the wires that the drawing mode calls for; rsp_tlast
// marks the final item caused by one input item. The csr channel writes the
// drawing mode (index 0) and the vertex count (index 1) and is always ready.
// An item is accepted every cycle while the job queue has room. Each index
// is registered in the classify stage and then in the job queue before its
// results are offered; results leave at one per cycle while the receiver is
// ready, and the sustained rate is set by the result port.
// After reset the highlight bitmap is swept clear, one entry per cycle, over
// all MAX_VERTICES entries; req_tready stays low during the sweep. When the
// receiver stalls, results wait in the four-entry job queue and req_tready
// drops once the queued jobs and the item in the classify stage fill the
// four entries.
module primitive_edge_generator_core import peg_pkg::*; #(
   parameter int MAX_VERTICES = 1024
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  logic [VERTEX_W-1:0]    req_tdata,   // [15:0] vertex
   input  logic [CMD_W-1:0]       req_tuser,   // [1:0] command
   input  logic                   req_tlast,
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   // [0] highlighted, [16:1] corner_a, [32:17] corner_b, [48:33] corner_c,
   // [64:49] corner_d, [67:65] corner_count, [71:68] zero
   output logic [RSP_DATA_W-1:0]  rsp_tdata,
   output logic                   rsp_tuser,   // [0] item_kind
   output logic                   rsp_tlast,
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_data
);

   localparam int AW = $clog2(MAX_VERTICES);
   localparam logic [VERTEX_W:0] MAX_LIMIT = (VERTEX_W+1)'(MAX_VERTICES);

   logic [MODE_W-1:0]  draw_mode_ff;
   logic [COUNT_W-1:0] vertex_count_ff;
   logic               clearing_ff;
   logic [AW-1:0]      clr_addr_ff;
   logic               accept;
   logic               mark_wr;
   logic               ram_we;
   logic [AW-1:0]      ram_waddr;
   logic               ram_wdata;
   logic               ram_rdata;
   logic               job_valid;
   peg_job_type        job;
   logic               front_busy;
   logic               q_pop;
   logic               q_valid;
   peg_job_type        q_head;
   logic [QCNT_W-1:0]  q_count;
   logic [QCNT_W:0]    q_load;

   // Configuration registers.
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         draw_mode_ff    <= '0;
         vertex_count_ff <= '0;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_DRAW_MODE:    draw_mode_ff    <= csr_data[MODE_W-1:0];
            CSR_VERTEX_COUNT: vertex_count_ff <= csr_data;
            default:          draw_mode_ff    <= draw_mode_ff;
         endcase
      end
   end

   // Bitmap clearing sweep after reset.
   always_ff @(posedge clock) begin
      if (reset) begin
         clearing_ff <= 1'b1;
         clr_addr_ff <= '0;
      end else if (clearing_ff) begin
         clr_addr_ff <= clr_addr_ff + 1'b1;
         if (clr_addr_ff == AW'(MAX_VERTICES - 1)) begin
            clearing_ff <= 1'b0;
         end
      end
   end

   // Input acceptance: room for this item and the one being classified.
   assign q_load     = {1'b0, q_count} + {{QCNT_W{1'b0}}, front_busy};
   assign req_tready = !clearing_ff && (q_load < (QCNT_W+1)'(QUEUE_DEPTH));
   assign accept     = req_tvalid && req_tready;

   // Bitmap writes come from the sweep or from mark and unmark commands.
   assign mark_wr   = accept && ((req_tuser == CMD_MARK) || (req_tuser == CMD_UNMARK)) &&
                      ({1'b0, req_tdata} < MAX_LIMIT);
   assign ram_we    = clearing_ff || mark_wr;
   assign ram_waddr = clearing_ff ? clr_addr_ff : req_tdata[AW-1:0];
   assign ram_wdata = !clearing_ff && (req_tuser == CMD_MARK);

   peg_ram #(
      .WIDTH(1),
      .DEPTH(MAX_VERTICES)
   ) u_map (
      .clock  (clock),
      .wr_en  (ram_we),
      .wr_addr(ram_waddr),
      .wr_data(ram_wdata),
      .rd_addr(req_tdata[AW-1:0]),
      .rd_data(ram_rdata)
   );

   peg_front #(
      .MAX_VERTICES(MAX_VERTICES)
   ) u_front (
      .clock       (clock),
      .reset       (reset),
      .acc_valid   (accept),
      .acc_cmd     (req_tuser),
      .acc_vertex  (req_tdata),
      .acc_last    (req_tlast),
      .lit_rdata   (ram_rdata),
      .draw_mode   (draw_mode_ff),
      .vertex_count(vertex_count_ff),
      .job_valid   (job_valid),
      .job         (job),
      .busy        (front_busy)
   );

   peg_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (job_valid),
      .push_job  (job),
      .pop       (q_pop),
      .head_valid(q_valid),
      .head_job  (q_head),
      .count     (q_count)
   );

   peg_back u_back (
      .clock     (clock),
      .reset     (reset),
      .head_valid(q_valid),
      .head_job  (q_head),
      .pop       (q_pop),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata (rsp_tdata),
      .rsp_tuser (rsp_tuser),
      .rsp_tlast (rsp_tlast)
   );

   // The job queue never holds more than its depth.
   assert property (@(posedge clock) disable iff (reset)
      q_count <= QCNT_W'(QUEUE_DEPTH))
      else $error("job queue overflow");

   // A face item is always highlighted and has three or four corners.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && (rsp_tuser == KIND_FACE)) |->
      (rsp_tdata[0] && ((rsp_tdata[67:65] == CORNERS_TRI) ||
                        (rsp_tdata[67:65] == CORNERS_QUAD))))
      else $error("face item malformed");

   // No result is offered while the bitmap sweep is running.
   assert property (@(posedge clock) disable iff (reset)
      clearing_ff |-> !rsp_tvalid)
      else $error("result during bitmap sweep");

endmodule

>>> verif/tb_primitive_edge_generator_core.sv
// Self-checking testbench for the primitive edge generator core.
`timescale 1ns / 100ps

module tb_primitive_edge_generator_core;
   import peg_pkg::*;

   localparam int MAX_VTX      = 1024;
   localparam int DRAIN_SLACK  = 12;
   localparam int QUIET_LIMIT  = 5000;

   // Codes that the package leaves unnamed.
   localparam logic [CMD_W-1:0]  CMD_UNKNOWN      = 2'd3;
   localparam logic [MODE_W-1:0] MODE_UNKNOWN_TOP = 4'd15;

   // One wire or face as it leaves the block.
   typedef struct packed {
      logic                 kind;
      logic                 lit;
      logic [VERTEX_W-1:0]  a;
      logic [VERTEX_W-1:0]  b;
      logic [VERTEX_W-1:0]  c;
      logic [VERTEX_W-1:0]  d;
      logic [CORNERS_W-1:0] cnt;
      logic                 last;
   } prim_result_type;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   logic [VERTEX_W-1:0]    req_tdata = '0;
   logic [CMD_W-1:0]       req_tuser = CMD_INDEX;
   logic                   req_tlast = 1'b0;
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0]  rsp_tdata;
   logic                   rsp_tuser;
   logic                   rsp_tlast;
   logic                   csr_valid = 1'b0;
   logic                   csr_ready;
   logic [CSR_INDEX_W-1:0] csr_index = CSR_DRAW_MODE;
   logic [CSR_DATA_W-1:0]  csr_data = '0;

   // Predictor state: configuration, list position, index history and bitmap.
   logic [MODE_W-1:0]   cfg_mode = MODE_POINTS;
   logic [COUNT_W-1:0]  cfg_count = '0;
   int unsigned         pos_phase = 0;
   int unsigned         seen_cnt = 0;
   logic [VERTEX_W-1:0] hist1 = '0;
   logic [VERTEX_W-1:0] hist2 = '0;
   logic [VERTEX_W-1:0] hist3 = '0;
   logic [VERTEX_W-1:0] list_first = '0;
   bit                  lit_map [MAX_VTX];

   prim_result_type expected_prims[$];
   prim_result_type step_prims[$];

   int          error_count = 0;
   int          send_idle_pct = 0;
   int          rsp_stall_pct = 0;
   int unsigned quiet_cycles = 0;

   primitive_edge_generator_core #(
      .MAX_VERTICES(MAX_VTX)
   ) u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   always #5 clock = ~clock;

   // Receiver backpressure, redrawn every cycle.
   always @(posedge clock) begin
      rsp_tready <= ($urandom_range(0, 99) >= rsp_stall_pct);
   end

   // A vertex takes part only below both the configured count and the bitmap size.
   function automatic bit vtx_ok(input logic [VERTEX_W-1:0] v);
      return (v < cfg_count) && (v < MAX_VTX);
   endfunction

   function automatic bit vtx_lit(input logic [VERTEX_W-1:0] v);
      return (v < MAX_VTX) ? lit_map[v] : 1'b0;
   endfunction

   function automatic void emit_wire(input logic [VERTEX_W-1:0] a,
                                     input logic [VERTEX_W-1:0] b);
      prim_result_type r;
      if (!vtx_ok(a) || !vtx_ok(b))
         return;
      r     = '0;
      r.kind = KIND_WIRE;
      r.lit  = vtx_lit(a) && vtx_lit(b);
      r.a    = a;
      r.b    = b;
      r.cnt  = CORNERS_WIRE;
      step_prims.push_back(r);
   endfunction

   // A face exists only when every corner is valid and highlighted.
   function automatic void emit_face(input logic [VERTEX_W-1:0] a,
                                     input logic [VERTEX_W-1:0] b,
                                     input logic [VERTEX_W-1:0] c,
                                     input logic [VERTEX_W-1:0] d,
                                     input bit quad);
      prim_result_type r;
      if (!vtx_ok(a) || !vtx_ok(b) || !vtx_ok(c) || (quad && !vtx_ok(d)))
         return;
      if (!vtx_lit(a) || !vtx_lit(b) || !vtx_lit(c) || (quad && !vtx_lit(d)))
         return;
      r      = '0;
      r.kind = KIND_FACE;
      r.lit  = 1'b1;
      r.a    = a;
      r.b    = b;
      r.c    = c;
      r.d    = quad ? d : '0;
      r.cnt  = quad ? CORNERS_QUAD : CORNERS_TRI;
      step_prims.push_back(r);
   endfunction

   // Works out the wires and faces caused by one accepted item.
   function automatic void assemble_primitive(input logic [CMD_W-1:0] cmd,
                                              input logic [VERTEX_W-1:0] v,
                                              input logic lst);
      int unsigned         p;
      int unsigned         s;
      logic [VERTEX_W-1:0] fst;
      logic [VERTEX_W-1:0] p1;
      logic [VERTEX_W-1:0] p2;
      logic [VERTEX_W-1:0] p3;
      bit                  w1;
      bit                  w2;
      bit                  w3;
      bit                  wf;
      prim_result_type     r;
      if (cmd == CMD_MARK || cmd == CMD_UNMARK) begin
         if (v < MAX_VTX)
            lit_map[v] = (cmd == CMD_MARK);
         return;
      end
      if (cmd != CMD_INDEX)
         return;
      p   = pos_phase;
      s   = seen_cnt;
      fst = (s == 0) ? v : list_first;
      p1  = hist1;
      p2  = hist2;
      p3  = hist3;
      if (s == 0)
         list_first = v;
      step_prims.delete();

      if (vtx_ok(v)) begin
         // The face comes before any wire.
         if (cfg_mode == MODE_TRIS && p % 3 == 2)
            emit_face(v, p1, p2, '0, 1'b0);
         else if (cfg_mode == MODE_TRI_STRIP && s >= 2)
            emit_face(v, p1, p2, '0, 1'b0);
         else if (cfg_mode == MODE_FAN && s >= 2)
            emit_face(v, p1, fst, '0, 1'b0);
         else if ((cfg_mode == MODE_QUADS || cfg_mode == MODE_QUAD_STRIP) && p % 4 == 3)
            emit_face(v, p1, p2, p3, 1'b1);

         w1 = (s >= 1) && ((cfg_mode == MODE_LINES && p % 2 == 1) ||
               cfg_mode == MODE_LOOP || cfg_mode == MODE_STRIP ||
               (cfg_mode == MODE_TRIS && p % 3 != 0) ||
               cfg_mode == MODE_TRI_STRIP || cfg_mode == MODE_FAN ||
               (cfg_mode == MODE_QUADS && p % 4 != 0) ||
               (cfg_mode == MODE_QUAD_STRIP && p % 2 == 1) ||
               cfg_mode == MODE_POLYGON);
         w2 = (s >= 2) && (cfg_mode == MODE_TRI_STRIP ||
               (cfg_mode == MODE_TRIS && p % 3 == 2) || cfg_mode == MODE_QUAD_STRIP);
         w3 = cfg_mode == MODE_QUADS && p % 4 == 3 && s >= 3;
         wf = ((cfg_mode == MODE_LOOP || cfg_mode == MODE_POLYGON) && lst) ||
              cfg_mode == MODE_FAN;
         if (w1)
            emit_wire(v, p1);
         if (w2)
            emit_wire(v, p2);
         if (w3)
            emit_wire(v, p3);
         if (wf)
            emit_wire(v, fst);
      end

      // History always advances, even for an out of range index.
      hist3 = hist2;
      hist2 = hist1;
      hist1 = v;
      if (lst) begin
         pos_phase = 0;
         seen_cnt  = 0;
      end else begin
         pos_phase = (p + 1) % 12;
         if (seen_cnt < 3)
            seen_cnt++;
      end

      for (int i = 0; i < step_prims.size(); i++) begin
         r      = step_prims[i];
         r.last = (i == step_prims.size() - 1);
         expected_prims.push_back(r);
      end
   endfunction

   function automatic void check_field(input string name,
                                       input logic [VERTEX_W-1:0] want,
                                       input logic [VERTEX_W-1:0] got);
      if (got !== want) begin
         $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
         error_count++;
      end
   endfunction

   // Result checking. Outputs only move at rising edges, so the values seen
   // at the falling edge are the ones the next rising edge accepts.
   always @(negedge clock) begin : rsp_check
      prim_result_type got;
      prim_result_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got.kind = rsp_tuser;
         got.lit  = rsp_tdata[0];
         got.a    = rsp_tdata[1 +: VERTEX_W];
         got.b    = rsp_tdata[1 + VERTEX_W +: VERTEX_W];
         got.c    = rsp_tdata[1 + 2 * VERTEX_W +: VERTEX_W];
         got.d    = rsp_tdata[1 + 3 * VERTEX_W +: VERTEX_W];
         got.cnt  = rsp_tdata[1 + 4 * VERTEX_W +: CORNERS_W];
         got.last = rsp_tlast;
         if (expected_prims.size() == 0) begin
            $display("%0t: unexpected result, expected none, actual kind %0d corners %0h %0h %0h %0h",
                     $time, got.kind, got.a, got.b, got.c, got.d);
            error_count++;
         end else begin
            want = expected_prims.pop_front();
            check_field("item_kind", VERTEX_W'(want.kind), VERTEX_W'(got.kind));
            check_field("highlighted", VERTEX_W'(want.lit), VERTEX_W'(got.lit));
            check_field("corner_a", want.a, got.a);
            check_field("corner_b", want.b, got.b);
            check_field("corner_c", want.c, got.c);
            check_field("corner_d", want.d, got.d);
            check_field("corner_count", VERTEX_W'(want.cnt), VERTEX_W'(got.cnt));
            check_field("last_of_run", VERTEX_W'(want.last), VERTEX_W'(got.last));
         end
      end
   end

   // Watchdog: ends the run when no channel has moved for too long.
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
          (csr_valid && csr_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles == QUIET_LIMIT) begin
         $display("%0t: watchdog expired, %0d results still expected", $time,
                  expected_prims.size());
         $display("Regression FAIL");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // Sends one item, with random idle cycles before it. With hold set the
   // sender first waits until every expected result has come back.
   task automatic send_item(input logic [CMD_W-1:0] cmd, input logic [VERTEX_W-1:0] vtx,
                            input logic lst, input bit hold);
      int gap;
      gap = 0;
      while (gap < 16 && $urandom_range(0, 99) < send_idle_pct)
         gap++;
      if (hold || gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
         if (hold) begin
            do @(posedge clock); while (expected_prims.size() != 0);
         end
      end
      req_tvalid <= 1'b1;
      req_tdata  <= vtx;
      req_tuser  <= cmd;
      req_tlast  <= lst;
      do @(posedge clock); while (!req_tready);
      assemble_primitive(cmd, vtx, lst);
   endtask

   // Drops the request, waits for every result and lets in-flight items settle.
   task automatic wait_idle();
      req_tvalid <= 1'b0;
      do @(posedge clock); while (expected_prims.size() != 0);
      repeat (DRAIN_SLACK) @(posedge clock);
   endtask

   // Writes both registers while the block is idle.
   task automatic configure(input logic [MODE_W-1:0] mode, input logic [COUNT_W-1:0] count);
      wait_idle();
      csr_valid <= 1'b1;
      csr_index <= CSR_DRAW_MODE;
      csr_data  <= CSR_DATA_W'(mode);
      do @(posedge clock); while (!csr_ready);
      cfg_mode = mode;
      csr_index <= CSR_VERTEX_COUNT;
      csr_data  <= count;
      do @(posedge clock); while (!csr_ready);
      cfg_count = count;
      csr_valid <= 1'b0;
   endtask

   // Index elements under the reset configuration cause nothing.
   task automatic test_reset_state();
      send_item(CMD_INDEX, 16'd3, 1'b1, 1'b0);
   endtask

   // Mark, unmark and unknown commands, then triangles with and without highlights.
   task automatic test_highlight_commands();
      configure(MODE_TRIS, COUNT_W'(MAX_VTX));
      send_item(CMD_MARK, 16'd0, 1'b0, 1'b0);
      send_item(CMD_MARK, 16'd1, 1'b1, 1'b0);
      send_item(CMD_MARK, 16'(MAX_VTX - 1), 1'b0, 1'b0);
      send_item(CMD_MARK, 16'(MAX_VTX), 1'b0, 1'b0);
      send_item(CMD_MARK, 16'hFFFF, 1'b1, 1'b0);
      send_item(CMD_UNMARK, 16'd1, 1'b0, 1'b0);
      send_item(CMD_UNKNOWN, 16'd1, 1'b1, 1'b0);
      send_item(CMD_INDEX, 16'd0, 1'b0, 1'b0);
      send_item(CMD_INDEX, 16'd1, 1'b0, 1'b0);
      send_item(CMD_INDEX, 16'd2, 1'b0, 1'b0);
      send_item(CMD_MARK, 16'd1, 1'b0, 1'b0);
      // Second triangle is fully lit and gives a face and two wires.
      send_item(CMD_INDEX, 16'(MAX_VTX - 1), 1'b0, 1'b1);
      send_item(CMD_INDEX, 16'd0, 1'b0, 1'b0);
      send_item(CMD_INDEX, 16'd1, 1'b1, 1'b0);
   endtask

   // Fan wire from the first element to itself, an out of range element in
   // the middle, and a loop closed on its only element.
   task automatic test_fan_and_loop();
      configure(MODE_FAN, COUNT_W'(MAX_VTX));
      send_item(CMD_INDEX, 16'(MAX_VTX - 1), 1'b0, 1'b0);
      send_item(CMD_INDEX, 16'hFFFF, 1'b0, 1'b0);
      send_item(CMD_INDEX, 16'd0, 1'b1, 1'b0);
      configure(MODE_LOOP, COUNT_W'(MAX_VTX));
      send_item(CMD_INDEX, 16'd2, 1'b1, 1'b0);
   endtask

   // Unknown draw mode and points mode produce nothing.
   task automatic test_inactive_modes();
      configure(MODE_UNKNOWN_TOP, COUNT_W'(MAX_VTX));
      send_item(CMD_INDEX, 16'd5, 1'b0, 1'b0);
      configure(MODE_POINTS, '0);
      send_item(CMD_INDEX, 16'd6, 1'b1, 1'b0);
   endtask

   // One random configuration followed by index lists drawn from a small
   // window of vertices, with highlight edits and some noise mixed in.
   task automatic random_segment(input int n_items);
      logic [MODE_W-1:0]   mode;
      logic [COUNT_W-1:0]  count;
      logic [VERTEX_W-1:0] vtx;
      logic                lst;
      int                  base;
      int                  sent;
      int                  len;
      mode = ($urandom_range(0, 9) == 0) ? MODE_W'($urandom_range(10, 15))
                                         : MODE_W'($urandom_range(0, 9));
      case ($urandom_range(0, 7))
         0:       count = COUNT_W'(MAX_VTX);
         1:       count = COUNT_W'($urandom_range(1, 8));
         2:       count = COUNT_W'(MAX_VTX - 1);
         3:       count = '0;
         default: count = COUNT_W'($urandom_range(0, MAX_VTX));
      endcase
      base = (count > 8) ? $urandom_range(0, count - 6) : 0;
      configure(mode, count);
      sent = 0;
      while (sent < n_items) begin
         len = $urandom_range(1, 13);
         for (int k = 0; k < len; k++) begin
            if ($urandom_range(0, 3) == 0) begin
               vtx = ($urandom_range(0, 9) == 0) ? VERTEX_W'($urandom)
                                                 : VERTEX_W'(base + $urandom_range(0, 7));
               send_item(($urandom_range(0, 3) == 0) ? CMD_UNMARK : CMD_MARK, vtx,
                         1'($urandom), 1'b0);
               sent++;
            end
            if ($urandom_range(0, 24) == 0)
               send_item(CMD_UNKNOWN, VERTEX_W'($urandom), 1'($urandom), 1'b0);
            vtx = ($urandom_range(0, 9) == 0) ? VERTEX_W'($urandom)
                                              : VERTEX_W'(base + $urandom_range(0, 7));
            // Mostly well-formed lists; a few end early or run on.
            lst = (k == len - 1) ? ($urandom_range(0, 7) != 0) : ($urandom_range(0, 29) == 0);
            send_item(CMD_INDEX, vtx, lst, $urandom_range(0, 39) == 0);
            sent++;
         end
      end
   endtask

   // Random traffic under each idling pattern in turn.
   task automatic test_random_lists();
      for (int ph = 0; ph < 4; ph++) begin
         case (ph)
            0: begin
               send_idle_pct = 0;
               rsp_stall_pct = 0;
            end
            1: begin
               send_idle_pct = 53;
               rsp_stall_pct = 0;
            end
            2: begin
               send_idle_pct = 0;
               rsp_stall_pct = 53;
            end
            default: begin
               send_idle_pct = 10;
               rsp_stall_pct = 10;
            end
         endcase
         for (int seg = 0; seg < 3; seg++)
            random_segment(10);
      end
   endtask

   task automatic finish_run();
      wait_idle();
      if (error_count == 0 && expected_prims.size() == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   endtask

   initial begin
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      test_reset_state();
      test_highlight_commands();
      test_fan_and_loop();
      test_inactive_modes();
      test_random_lists();
      finish_run();
   end

endmodule

>>> sim.f
src/peg_pkg.sv
src/peg_ram.sv
src/peg_front.sv
src/peg_queue.sv
src/peg_back.sv
src/primitive_edge_generator_core.sv
verif/tb_primitive_edge_generator_core.sv
